/* src/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

/* src/aes_ctr_pkg.sv */
// package: types, s-box and round helpers for the aes-256 ctr block
package aes_ctr_pkg;

  localparam int unsigned RoundKeyCount = 15;
  localparam int unsigned KeyHalves     = 2 * RoundKeyCount;
  localparam int unsigned LastRound     = RoundKeyCount - 1;
  localparam int unsigned BlockBytes    = 16;
  localparam int unsigned RoundW        = $clog2(RoundKeyCount);
  localparam int unsigned FifoDepth     = 2;

  typedef enum logic {
    REQ_KEY  = 1'b0,
    REQ_DATA = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } eng_state_e;

  // work item passed from front to back
  typedef struct packed {
    logic [63:0] ctr;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  count;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes, shiftrows and optional mixcolumns; byte j at bits 8j+7:8j
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c)   +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return last ? t : m;
  endfunction

endpackage

/* src/aes256_ctr_keystream_xor.sv */
// top level: aes-256 counter mode keystream xor
// in channel: in_valid_i/in_stall_o carry one beat, either a round key half
// (req_type_i 0, key_slot_i, key_word_i) or a data block (req_type_i 1).
// key beats stall while a data block waits in the queue or runs its rounds,
// so every block uses the keys loaded before it.
// data beats take the current counter (or 1 when start_message_i is set),
// go into a two-entry job queue and then to the round engine.
// out channel: out_valid_o/out_stall_i give one beat per data block with
// result_low_o, result_high_o and result_bytes_o; invalid bytes read zero.
// an accepted data beat is queued; the engine pops the job, runs the key
// xor and 14 rounds and holds the result in the output register. it pops
// the next job only after that result is accepted, so blocks do not
// overlap in the engine.
// a stalled result holds its value; the queue absorbs two more blocks,
// then in_stall_o rises for data beats.
// reset clears the counter to 1 and empties the queue; the key store
// holds nothing defined until written.
module aes256_ctr_keystream_xor import aes_ctr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [4:0]  key_slot_i,
  input  logic [63:0] key_word_i,
  input  logic        start_message_i,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  output logic [4:0]  result_bytes_o
);

  logic key_we, job_valid, job_full, job_pop, job_empty, eng_busy;
  job_t job_in, job_out;

  aes_ctr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .start_message_i,
    .data_low_i, .data_high_i, .byte_count_i,
    .key_we_o(key_we), .job_valid_o(job_valid), .job_full_i(job_full),
    .job_empty_i(job_empty), .eng_busy_i(eng_busy), .job_o(job_in)
  );

  aes_ctr_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(job_valid), .push_data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .empty_o(job_empty), .pop_data_o(job_out)
  );

  aes_ctr_back u_back (
    .clk_i, .rst_ni, .key_we_i(key_we), .key_slot_i, .key_word_i,
    .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .eng_busy_o(eng_busy),
    .out_valid_o, .out_stall_i, .result_low_o, .result_high_o, .result_bytes_o
  );

endmodule

/* src/aes_ctr_front.sv */
// front: classifies beats, holds the counter and pushes data jobs
module aes_ctr_front import aes_ctr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        start_message_i,
  input  logic [63:0] data_low_i,
  input  logic [63:0] data_high_i,
  input  logic [4:0]  byte_count_i,
  output logic        key_we_o,
  output logic        job_valid_o,
  input  logic        job_full_i,
  input  logic        job_empty_i,
  input  logic        eng_busy_i,
  output job_t        job_o
);

  logic [63:0] ctr_q, ctr_d, ctr_use;
  logic        is_data;

  // key beats wait until no earlier data block can still read the keys
  assign is_data     = req_type_i == REQ_DATA;
  assign in_stall_o  = is_data ? job_full_i : (eng_busy_i || !job_empty_i);
  assign key_we_o    = in_valid_i && !is_data && !in_stall_o;
  assign job_valid_o = in_valid_i && is_data && !job_full_i;
  assign ctr_use     = start_message_i ? 64'd1 : ctr_q;

  always_comb begin
    ctr_d = ctr_q;
    if (job_valid_o) ctr_d = ctr_use + 64'd1;
  end

  always_comb begin
    job_o.ctr       = ctr_use;
    job_o.data_low  = data_low_i;
    job_o.data_high = data_high_i;
    job_o.count     = (byte_count_i > 5'(BlockBytes)) ? 5'(BlockBytes) : byte_count_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctr_q <= 64'd1;
    else         ctr_q <= ctr_d;
  end

endmodule

/* src/aes_ctr_fifo.sv */
// short job queue between front and back
module aes_ctr_fifo import aes_ctr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t pop_data_o
);

  `include "assert_macros.svh"

  job_t       mem_q [FifoDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'(FifoDepth);
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `ASSERT_CLK(a_no_overflow, !(push_i && full_o), "push into full queue")
  `ASSERT_CLK(a_no_underflow, !(pop_i && empty_o), "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, cnt_q <= 2'(FifoDepth), "queue count out of range")

endmodule

/* src/aes_ctr_back.sv */
// back: key store, iterative aes round engine and output register
module aes_ctr_back import aes_ctr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        key_we_i,
  input  logic [4:0]  key_slot_i,
  input  logic [63:0] key_word_i,
  input  logic        job_empty_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        eng_busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  output logic [4:0]  result_bytes_o
);

  `include "assert_macros.svh"

  // round key store, two halves read together as one row
  logic [63:0] key_lo_mem [RoundKeyCount];
  logic [63:0] key_hi_mem [RoundKeyCount];
  logic [63:0] rk_lo_q, rk_hi_q;
  logic [RoundW-1:0] rd_idx;

  eng_state_e    state_q, state_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [127:0]  st_q, st_d;
  job_t          job_q;
  logic [127:0]  ks, din, mask;
  logic [127:0]  res_q;
  logic [4:0]    bytes_q;

  always_ff @(posedge clk_i) begin
    if (key_we_i && key_slot_i < 5'(KeyHalves)) begin
      if (key_slot_i[0]) key_hi_mem[key_slot_i[4:1]] <= key_word_i;
      else               key_lo_mem[key_slot_i[4:1]] <= key_word_i;
    end
    rk_lo_q <= key_lo_mem[rd_idx];
    rk_hi_q <= key_hi_mem[rd_idx];
  end

  // key row for the round that comes next
  always_comb begin
    case (state_q)
      ST_IDLE:  rd_idx = '0;
      ST_ROUND: rd_idx = (rnd_q == RoundW'(LastRound)) ? '0 : rnd_q + 1'b1;
      default:  rd_idx = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          rnd_d     = '0;
          state_d   = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RoundW'(LastRound)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (state_q)
      ST_ROUND: begin
        if (rnd_q == '0) st_d = {64'd0, job_q.ctr} ^ {rk_hi_q, rk_lo_q};
        else st_d = aes_round(st_q, rnd_q == RoundW'(LastRound)) ^ {rk_hi_q, rk_lo_q};
      end
      default: st_d = st_q;
    endcase
  end

  assign ks  = st_d;
  assign din = {job_q.data_high, job_q.data_low};
  always_comb begin
    for (int j = 0; j < BlockBytes; j++) begin
      mask[8*j +: 8] = (5'(j) < job_q.count) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    st_q <= st_d;
    if (state_q == ST_ROUND && rnd_q == RoundW'(LastRound)) begin
      res_q   <= (din ^ ks) & mask;
      bytes_q <= job_q.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  assign eng_busy_o     = state_q == ST_ROUND;
  assign out_valid_o    = state_q == ST_OUT;
  assign result_low_o   = res_q[63:0];
  assign result_high_o  = res_q[127:64];
  assign result_bytes_o = bytes_q;

  `ASSERT_CLK(a_pop_idle, job_pop_o |-> state_q == ST_IDLE, "pop while busy")
  `ASSERT_CLK(a_round_range, state_q == ST_ROUND |-> rnd_q <= RoundW'(LastRound),
              "round index out of range")
  `ASSERT_CLK(a_out_after_last, $rose(out_valid_o) |-> $past(rnd_q) == RoundW'(LastRound),
              "result before last round")

endmodule
